FILE: rtl/ksfa_pkg.sv
// Shared constants and types for the key slot find-or-allocate block.
`default_nettype none

package ksfa_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 4;

    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    typedef enum logic [1:0] {
        OUT_REUSED    = 2'd0,
        OUT_ALLOCATED = 2'd1,
        OUT_FULL      = 2'd2
    } outcome_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_POST = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ksfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ksfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/key_slot_find_or_allocate.sv
// Key slot find-or-allocate: top level with scan sequencer and key RAM.
// Flow: an empty-marker key or an empty table goes straight from accept to the result state;
//   otherwise each occupied slot is scanned in turn, costing one RAM read plus one compare.
// One word at a time: a new word is taken only after the last result is posted.
// Reset: asynchronous, active low; clears the fill count and output valid, table reads empty.
// No clearing pass: slots at or above the fill count are never scanned and count as empty.
`default_nettype none

module key_slot_find_or_allocate
    import ksfa_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [KEY_W-1:0] lookup_key,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic             [INDEX_W-1:0] slot_index,
    output logic             [1:0]       outcome
);

    // Slots fill strictly from the bottom and are never released, and an
    // allocated key is never the empty marker (that key always matches an
    // empty slot first). So the table is slots [0, fill) holding real keys
    // and everything above treated as empty, since the scan never reads it.
    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOT_COUNT);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ADDR_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  slot_index_reg, slot_index_next;
    outcome_t            outcome_reg, outcome_next;

    logic                ram_we;
    logic [KEY_W-1:0]    ram_rdata;
    logic                has_room;
    logic                scan_last;

    ksfa_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (key_reg),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign has_room  = (fill_reg < SLOT_MAX);
    // Last occupied slot is fill - 1.
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == fill_reg);

    // Only the idle state takes a new word.
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign slot_index = slot_index_reg;
    assign outcome    = outcome_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        key_next        = key_reg;
        scan_idx_next   = scan_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        out_valid_next  = out_valid_reg & out_stall;
        slot_index_next = slot_index_reg;
        outcome_next    = outcome_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = $unsigned(lookup_key);
                    scan_idx_next = '0;
                    hit_idx_next  = fill_reg[ADDR_W-1:0];
                    if ($unsigned(lookup_key) == EMPTY_KEY)
                    begin
                        // empty marker matches the lowest empty slot, if any
                        hit_next   = has_room;
                        state_next = ST_POST;
                    end
                    else if (fill_reg == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                // read address issued this cycle, data lands in CMP
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                    state_next   = ST_POST;
                end
                else if (scan_last)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                    state_next    = ST_READ;
                end
            end

            ST_POST:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (hit_reg)
                    begin
                        slot_index_next = INDEX_W'(hit_idx_reg);
                        outcome_next    = OUT_REUSED;
                    end
                    else if (has_room)
                    begin
                        ram_we          = 1'b1;
                        slot_index_next = INDEX_W'(fill_reg[ADDR_W-1:0]);
                        outcome_next    = OUT_ALLOCATED;
                        fill_next       = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        slot_index_next = '0;
                        outcome_next    = OUT_FULL;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        hit_idx_reg    <= hit_idx_next;
        slot_index_reg <= slot_index_next;
        outcome_reg    <= outcome_next;
    end

`ifndef SYNTH
    // fill count never runs past the table
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOT_MAX)
        else $error("fill count above slot count");

    // fill only moves by one, and only with a RAM write
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> ($past(ram_we) && fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("fill count changed without allocation");

    // a full result always carries slot zero
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && outcome_reg == OUT_FULL) |-> (slot_index_reg == '0))
        else $error("full result with nonzero slot");

    // an allocation writes the key and hands out a fresh word
    a_alloc_word: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (out_valid_reg && outcome_reg == OUT_ALLOCATED && state_reg == ST_IDLE))
        else $error("allocation without matching result");

    // an empty-marker key is never written into the table
    a_no_empty_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (key_reg != EMPTY_KEY))
        else $error("empty marker allocated");
`endif

endmodule

`default_nettype wire
